/* hdl/bcw_pkg.sv */
// ----------------------------------------------------------------------------
// Barycentric weights package
// Fixed result width and the configuration register map.
// ----------------------------------------------------------------------------
package bcw_pkg;

  // Width of each weight result, signed Q15.16 by default
  localparam int WEIGHT_WIDTH = 32;

  // Configuration register index width
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_V0_X,
    REG_V0_Y,
    REG_V1_X,
    REG_V1_Y,
    REG_V2_X,
    REG_V2_Y
  } cfg_reg_t;

endpackage

/* hdl/bcw_divider.sv */
// ----------------------------------------------------------------------------
// Barycentric weights pipelined divider
// Unsigned restoring divider, one quotient bit per register stage. The
// numerator and quotient share one shift register per stage: numerator bits
// leave at the top while quotient bits enter at the bottom. A sign flag rides
// along with the data.
// ----------------------------------------------------------------------------
module bcw_divider #(
  parameter int NUM_WIDTH = 51,
  parameter int DEN_WIDTH = 35
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_WIDTH-1:0] num,
  input  logic [DEN_WIDTH-1:0] den,
  input  logic                 neg_in,
  output logic [NUM_WIDTH-1:0] quo,
  output logic                 neg_out
);

  // Per-stage registers; divisor is only needed up to the next-to-last stage
  logic [DEN_WIDTH-1:0] rem_r [NUM_WIDTH];
  logic [NUM_WIDTH-1:0] nq_r  [NUM_WIDTH];
  logic                 neg_r [NUM_WIDTH];
  logic [DEN_WIDTH-1:0] den_r [NUM_WIDTH-1];

  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
    logic [DEN_WIDTH-1:0] rem_in;
    logic [NUM_WIDTH-1:0] nq_in;
    logic [DEN_WIDTH-1:0] den_in;
    logic                 neg_s;
    logic [DEN_WIDTH:0]   trial;
    logic [DEN_WIDTH:0]   diff;
    logic                 ge;

    // Select stage inputs
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign neg_s  = neg_in;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign nq_in  = nq_r[i-1];
      assign den_in = den_r[i-1];
      assign neg_s  = neg_r[i-1];
    end

    // Bring down one numerator bit and try the subtraction
    assign trial = {rem_in, nq_in[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    // Advance one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
        nq_r[i]  <= {nq_in[NUM_WIDTH-2:0], ge};
        neg_r[i] <= neg_s;
      end
    end

    // Pass the divisor on to the next stage
    if (i < NUM_WIDTH - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo     = nq_r[NUM_WIDTH-1];
  assign neg_out = neg_r[NUM_WIDTH-1];

endmodule

/* hdl/barycentric_weights_top.sv */
// ----------------------------------------------------------------------------
// Barycentric weights top level
// Per-pixel barycentric weights against a triangle held in config registers.
// ----------------------------------------------------------------------------
// Takes one pixel position per cycle while in_stall is low and returns one
// result per pixel, in order. Depth is set by the two restoring dividers for
// u and v, which resolve one quotient bit per pipeline stage; ahead of them
// sit stages for edge differences, products, cross products and magnitudes,
// and behind them sign restore and saturation. The whole pipeline holds when
// a finished result is stalled at the output, so in_stall follows out_stall
// while out_valid is high. Vertices are written through the cfg channel,
// which is always ready, and must only change while no transaction is in
// flight. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module barycentric_weights_top
  import bcw_pkg::*;
#(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]     cfg_data,
  // pixel channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_WIDTH-1:0] pixel_x,
  input  logic signed [COORD_WIDTH-1:0] pixel_y,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [WEIGHT_WIDTH-1:0] weight_first,
  output logic signed [WEIGHT_WIDTH-1:0] weight_second,
  output logic signed [WEIGHT_WIDTH-1:0] weight_third,
  output logic                       degenerate,
  output logic                       clipped
);

  // Derived widths
  localparam int DW   = COORD_WIDTH + 1;          // edge difference
  localparam int PW   = 2 * DW;                   // product
  localparam int XW   = PW + 1;                   // cross product
  localparam int NW   = XW + WEIGHT_FRAC_BITS;    // scaled numerator / quotient
  localparam int SW   = NW + 3;                   // exact weight
  localparam int SATW = (SW > WEIGHT_WIDTH) ? SW : WEIGHT_WIDTH + 1;

  localparam logic [SATW-1:0] ONE = SATW'(1) << WEIGHT_FRAC_BITS;
  localparam logic [WEIGHT_WIDTH-1:0] WMAX = {1'b0, {(WEIGHT_WIDTH-1){1'b1}}};
  localparam logic [WEIGHT_WIDTH-1:0] WMIN = {1'b1, {(WEIGHT_WIDTH-1){1'b0}}};

  function automatic logic signed [DW-1:0] sext(input logic [COORD_WIDTH-1:0] a);
    return {a[COORD_WIDTH-1], a};
  endfunction

  function automatic logic [XW-1:0] mag(input logic signed [XW-1:0] a);
    return a[XW-1] ? -a : a;
  endfunction

  function automatic logic fits(input logic [SATW-1:0] a);
    return (&a[SATW-1:WEIGHT_WIDTH-1]) || !(|a[SATW-1:WEIGHT_WIDTH-1]);
  endfunction

  function automatic logic [WEIGHT_WIDTH-1:0] sat(input logic [SATW-1:0] a);
    if (fits(a)) begin
      return a[WEIGHT_WIDTH-1:0];
    end
    return a[SATW-1] ? WMIN : WMAX;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COORD_WIDTH-1:0] v0_x, v0_y, v1_x, v1_y, v2_x, v2_y;

  assign cfg_ready = 1'b1;

  // Write one vertex coordinate; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      v0_x <= '0;
      v0_y <= '0;
      v1_x <= '0;
      v1_y <= '0;
      v2_x <= '0;
      v2_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_V0_X: v0_x <= cfg_data;
        REG_V0_Y: v0_y <= cfg_data;
        REG_V1_X: v1_x <= cfg_data;
        REG_V1_Y: v1_y <= cfg_data;
        REG_V2_X: v2_x <= cfg_data;
        REG_V2_Y: v2_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic adv;

  // Hold every stage while a finished result waits at the output
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s3_degen, s4_degen, s5_degen;
  logic dv_valid [NW];
  logic dv_degen [NW];

  // Stage 1: edge differences
  logic signed [DW-1:0] s1_ax, s1_ay, s1_bx, s1_by, s1_cx, s1_cy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax <= sext(v1_x) - sext(v0_x);
      s1_ay <= sext(v1_y) - sext(v0_y);
      s1_bx <= sext(v2_x) - sext(v0_x);
      s1_by <= sext(v2_y) - sext(v0_y);
      s1_cx <= sext(v0_x) - sext(pixel_x);
      s1_cy <= sext(v0_y) - sext(pixel_y);
    end
  end

  // Stage 2: products
  logic signed [PW-1:0] s2_bx_cy, s2_cx_by, s2_cx_ay, s2_ax_cy, s2_ax_by, s2_bx_ay;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_bx_cy <= s1_bx * s1_cy;
      s2_cx_by <= s1_cx * s1_by;
      s2_cx_ay <= s1_cx * s1_ay;
      s2_ax_cy <= s1_ax * s1_cy;
      s2_ax_by <= s1_ax * s1_by;
      s2_bx_ay <= s1_bx * s1_ay;
    end
  end

  // Stage 3: cross products; cz is the signed double area
  logic signed [XW-1:0] s3_cu, s3_cv, s3_cz;
  logic signed [XW-1:0] cz_comb;

  assign cz_comb = XW'(s2_ax_by) - XW'(s2_bx_ay);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cu    <= XW'(s2_bx_cy) - XW'(s2_cx_by);
      s3_cv    <= XW'(s2_cx_ay) - XW'(s2_ax_cy);
      s3_cz    <= cz_comb;
      s3_degen <= (cz_comb == '0);
    end
  end

  // Stage 4: magnitudes, scaled numerators and quotient signs
  logic [NW-1:0] s4_num_u, s4_num_v;
  logic [XW-1:0] s4_den;
  logic          s4_neg_u, s4_neg_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_num_u <= {mag(s3_cu), {WEIGHT_FRAC_BITS{1'b0}}};
      s4_num_v <= {mag(s3_cv), {WEIGHT_FRAC_BITS{1'b0}}};
      s4_den   <= mag(s3_cz);
      s4_neg_u <= s3_cu[XW-1] ^ s3_cz[XW-1];
      s4_neg_v <= s3_cv[XW-1] ^ s3_cz[XW-1];
      s4_degen <= s3_degen;
    end
  end

  // Dividers: one quotient bit per stage
  logic [NW-1:0] quo_u, quo_v;
  logic          neg_u, neg_v;

  bcw_divider #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (XW)
  ) u_div_u (
    .clk     (clk),
    .en      (adv),
    .num     (s4_num_u),
    .den     (s4_den),
    .neg_in  (s4_neg_u),
    .quo     (quo_u),
    .neg_out (neg_u)
  );

  bcw_divider #(
    .NUM_WIDTH (NW),
    .DEN_WIDTH (XW)
  ) u_div_v (
    .clk     (clk),
    .en      (adv),
    .num     (s4_num_v),
    .den     (s4_den),
    .neg_in  (s4_neg_v),
    .quo     (quo_v),
    .neg_out (neg_v)
  );

  // Carry the degenerate flag alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_degen[0] <= s4_degen;
      for (int i = 1; i < NW; i++) begin
        dv_degen[i] <= dv_degen[i-1];
      end
    end
  end

  // Stage 5: restore quotient signs
  logic [SATW-1:0] s5_u, s5_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_u     <= neg_u ? -SATW'(quo_u) : SATW'(quo_u);
      s5_v     <= neg_v ? -SATW'(quo_v) : SATW'(quo_v);
      s5_degen <= dv_degen[NW-1];
    end
  end

  // Stage 6: first weight, saturation and output register
  logic [SATW-1:0] w_comb;
  logic            clip_comb;

  assign w_comb    = ONE - s5_u - s5_v;
  assign clip_comb = !fits(w_comb) || !fits(s5_u) || !fits(s5_v);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s5_degen) begin
        weight_first  <= '0;
        weight_second <= '0;
        weight_third  <= '0;
        clipped       <= 1'b0;
      end else begin
        weight_first  <= sat(w_comb);
        weight_second <= sat(s5_u);
        weight_third  <= sat(s5_v);
        clipped       <= clip_comb;
      end
      degenerate <= s5_degen;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NW; i++) begin
        dv_valid[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_valid    <= in_valid;
      s2_valid    <= s1_valid;
      s3_valid    <= s2_valid;
      s4_valid    <= s3_valid;
      dv_valid[0] <= s4_valid;
      for (int i = 1; i < NW; i++) begin
        dv_valid[i] <= dv_valid[i-1];
      end
      s5_valid  <= dv_valid[NW-1];
      out_valid <= s5_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      weight_first == '0 && weight_second == '0 && weight_third == '0 && !clipped)
    else $error("degenerate result carries nonzero weights or clip");

  a_sum_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && !clipped |->
      WEIGHT_WIDTH'(weight_first + weight_second + weight_third)
        == ONE[WEIGHT_WIDTH-1:0])
    else $error("unclipped weights do not sum to one");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted transaction did not enter the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid && !s5_valid)
    else $error("pipeline not empty after reset");

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Barycentric weights testbench
// Self-checking bench: an in-bench weight predictor follows every pixel
// transaction and each result is compared against it in order, under random
// idling and stalling on both channels and with long output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import bcw_pkg::*;

  localparam int COORD_W         = 16;
  localparam int FRAC_BITS       = 16;
  localparam int CLK_PERIOD      = 10;
  localparam int PIPE_LATENCY    = 2 * COORD_W + FRAC_BITS + 9;
  localparam int QUIET_LIMIT     = 4000;
  localparam int REPORT_LIMIT    = 10;
  localparam int NUM_VERTEX_REGS = int'(REG_V2_Y) + 1;
  localparam int COORD_MIN       = -(1 << (COORD_W - 1));
  localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
  localparam longint ONE_WEIGHT  = longint'(1) <<< FRAC_BITS;
  localparam longint WEIGHT_MAX  = (longint'(1) <<< (WEIGHT_WIDTH - 1)) - 1;
  localparam longint WEIGHT_MIN  = -WEIGHT_MAX - 1;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] weight_first;
    logic signed [WEIGHT_WIDTH-1:0] weight_second;
    logic signed [WEIGHT_WIDTH-1:0] weight_third;
    logic                           degenerate;
    logic                           clipped;
  } weights_t;

  logic clk = 1'b0;
  logic rst;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]   cfg_index;
  logic [COORD_W-1:0]           cfg_data;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_W-1:0]    pixel_x;
  logic signed [COORD_W-1:0]    pixel_y;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [WEIGHT_WIDTH-1:0] weight_first;
  logic signed [WEIGHT_WIDTH-1:0] weight_second;
  logic signed [WEIGHT_WIDTH-1:0] weight_third;
  logic                         degenerate;
  logic                         clipped;

  // Predictor copy of the vertex registers
  logic signed [COORD_W-1:0] vertex_reg [NUM_VERTEX_REGS];
  weights_t pending_weights [$];
  weights_t want_w;
  weights_t got_w;

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int src_idle_pct;
  int sink_stall_pct;
  int sink_hold_cycles;

  // Bounds of the loaded triangle, used to aim random pixels
  int tri_lo_x, tri_hi_x, tri_lo_y, tri_hi_y, tri_margin;

  barycentric_weights_top #(
    .COORD_WIDTH      (COORD_W),
    .WEIGHT_FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .weight_first  (weight_first),
    .weight_second (weight_second),
    .weight_third  (weight_third),
    .degenerate    (degenerate),
    .clipped       (clipped)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Weight predictor
  // --------------------------------------------------------------------------

  // Clamp a weight to the result width; the top bit flags saturation
  function automatic logic [WEIGHT_WIDTH:0] saturate_weight(input longint val);
    if (val > WEIGHT_MAX)
      return {1'b1, WEIGHT_WIDTH'(WEIGHT_MAX)};
    if (val < WEIGHT_MIN)
      return {1'b1, WEIGHT_WIDTH'(WEIGHT_MIN)};
    return {1'b0, WEIGHT_WIDTH'(val)};
  endfunction

  function automatic weights_t predict_weights(input logic signed [COORD_W-1:0] px,
                                               input logic signed [COORD_W-1:0] py);
    longint ax, ay, bx, by, cx, cy, cu, cv, cz, u, v;
    logic [WEIGHT_WIDTH:0] sat_first, sat_second, sat_third;
    weights_t r;
    ax = longint'(vertex_reg[REG_V1_X]) - longint'(vertex_reg[REG_V0_X]);
    ay = longint'(vertex_reg[REG_V1_Y]) - longint'(vertex_reg[REG_V0_Y]);
    bx = longint'(vertex_reg[REG_V2_X]) - longint'(vertex_reg[REG_V0_X]);
    by = longint'(vertex_reg[REG_V2_Y]) - longint'(vertex_reg[REG_V0_Y]);
    cx = longint'(vertex_reg[REG_V0_X]) - longint'(px);
    cy = longint'(vertex_reg[REG_V0_Y]) - longint'(py);
    cu = bx * cy - cx * by;
    cv = cx * ay - ax * cy;
    cz = ax * by - bx * ay;
    r = '0;
    // Zero area: flag it and leave every weight at zero
    if (cz == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // Signed division truncates toward zero
    u = (cu * ONE_WEIGHT) / cz;
    v = (cv * ONE_WEIGHT) / cz;
    sat_first  = saturate_weight(ONE_WEIGHT - u - v);
    sat_second = saturate_weight(u);
    sat_third  = saturate_weight(v);
    r.weight_first  = sat_first[WEIGHT_WIDTH-1:0];
    r.weight_second = sat_second[WEIGHT_WIDTH-1:0];
    r.weight_third  = sat_third[WEIGHT_WIDTH-1:0];
    r.clipped = sat_first[WEIGHT_WIDTH] | sat_second[WEIGHT_WIDTH] | sat_third[WEIGHT_WIDTH];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_w.weight_first  = weight_first;
      got_w.weight_second = weight_second;
      got_w.weight_third  = weight_third;
      got_w.degenerate    = degenerate;
      got_w.clipped       = clipped;
      if (pending_weights.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: w=%0d u=%0d v=%0d deg=%b clip=%b",
                   $signed(got_w.weight_first), $signed(got_w.weight_second),
                   $signed(got_w.weight_third), got_w.degenerate, got_w.clipped);
      end else begin
        want_w = pending_weights.pop_front();
        if (got_w.weight_first !== want_w.weight_first ||
            got_w.weight_second !== want_w.weight_second ||
            got_w.weight_third !== want_w.weight_third ||
            got_w.degenerate !== want_w.degenerate ||
            got_w.clipped !== want_w.clipped) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: want w=%0d u=%0d v=%0d deg=%b clip=%b, got w=%0d u=%0d v=%0d deg=%b clip=%b",
                     $signed(want_w.weight_first), $signed(want_w.weight_second),
                     $signed(want_w.weight_third), want_w.degenerate, want_w.clipped,
                     $signed(got_w.weight_first), $signed(got_w.weight_second),
                     $signed(got_w.weight_third), got_w.degenerate, got_w.clipped);
        end
      end
    end
  end

  // Drive output stall: a requested hold first, random stalls otherwise
  always @(negedge clk) begin
    if (sink_hold_cycles > 0) begin
      out_stall <= 1'b1;
      sink_hold_cycles = sink_hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  task automatic send_pixel(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= px;
    pixel_y  <= py;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    pending_weights.push_back(predict_weights(px, py));
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_weights.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [COORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    if (idx < NUM_VERTEX_REGS)
      vertex_reg[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write random data to every index past the vertex registers
  task automatic write_unmapped();
    for (int idx = NUM_VERTEX_REGS; idx < (1 << CFG_INDEX_WIDTH); idx++)
      write_register(CFG_INDEX_WIDTH'(idx), COORD_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int clamp_coord(input int val);
    if (val < COORD_MIN)
      return COORD_MIN;
    if (val > COORD_MAX)
      return COORD_MAX;
    return val;
  endfunction

  function automatic int pick_between(input int lo, input int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int min3(input int a, input int b, input int c);
    int m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  // Load a triangle once the pipeline is empty
  task automatic load_triangle(input int x0, input int y0, input int x1, input int y1,
                               input int x2, input int y2, input int margin);
    drain_results();
    write_register(REG_V0_X, COORD_W'(x0));
    write_register(REG_V0_Y, COORD_W'(y0));
    write_register(REG_V1_X, COORD_W'(x1));
    write_register(REG_V1_Y, COORD_W'(y1));
    write_register(REG_V2_X, COORD_W'(x2));
    write_register(REG_V2_Y, COORD_W'(y2));
    tri_lo_x   = min3(x0, x1, x2);
    tri_hi_x   = max3(x0, x1, x2);
    tri_lo_y   = min3(y0, y1, y2);
    tri_hi_y   = max3(y0, y1, y2);
    tri_margin = margin;
  endtask

  task automatic load_random_triangle();
    int kind, base_x, base_y, spread;
    int vx [3];
    int vy [3];
    kind = $urandom_range(99);
    if (kind < 50) begin
      // ordinary triangle of random size somewhere on screen
      spread = 1 << $urandom_range(2, 12);
      base_x = int'($urandom_range(40000)) - 20000;
      base_y = int'($urandom_range(40000)) - 20000;
      foreach (vx[k]) begin
        vx[k] = clamp_coord(base_x + pick_between(-spread, spread));
        vy[k] = clamp_coord(base_y + pick_between(-spread, spread));
      end
    end else if (kind < 65) begin
      // vertices anywhere in the full coordinate range
      spread = COORD_MAX;
      foreach (vx[k]) begin
        vx[k] = pick_between(COORD_MIN, COORD_MAX);
        vy[k] = pick_between(COORD_MIN, COORD_MAX);
      end
    end else if (kind < 80) begin
      // sliver with tiny area, so far pixels push the weights out of range
      spread = COORD_MAX;
      base_x = pick_between(COORD_MIN, COORD_MAX);
      base_y = pick_between(COORD_MIN, COORD_MAX);
      foreach (vx[k]) begin
        vx[k] = clamp_coord(base_x + pick_between(-2, 2));
        vy[k] = clamp_coord(base_y + pick_between(-2, 2));
      end
    end else if (kind < 90) begin
      // vertices at the ends and the centre of the coordinate range
      spread = 256;
      foreach (vx[k]) begin
        vx[k] = extreme_coord();
        vy[k] = extreme_coord();
      end
    end else begin
      // zero area: coincident or collinear vertices
      spread = 1024;
      foreach (vx[k]) begin
        vx[k] = pick_between(COORD_MIN, COORD_MAX);
        vy[k] = pick_between(COORD_MIN, COORD_MAX);
      end
      case ($urandom_range(2))
        0: begin
          vx[1] = vx[0];
          vy[1] = vy[0];
          vx[2] = vx[0];
          vy[2] = vy[0];
        end
        1: begin
          vx[2] = vx[0];
          vy[2] = vy[0];
        end
        default: begin
          vx[1] = vx[0];
          vx[2] = vx[0];
        end
      endcase
    end
    load_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], spread);
  endtask

  // Mostly pixels around the triangle, some anywhere, some at the ends or centre of the range
  task automatic send_random_pixel();
    int pick;
    logic [COORD_W-1:0] px, py;
    pick = $urandom_range(99);
    if (pick < 70) begin
      px = COORD_W'(clamp_coord(pick_between(tri_lo_x - tri_margin, tri_hi_x + tri_margin)));
      py = COORD_W'(clamp_coord(pick_between(tri_lo_y - tri_margin, tri_hi_y + tri_margin)));
    end else if (pick < 90) begin
      px = COORD_W'($urandom);
      py = COORD_W'($urandom);
    end else begin
      px = COORD_W'(extreme_coord());
      py = COORD_W'(extreme_coord());
    end
    send_pixel(px, py);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // All vertices reset to the origin, so every pixel is degenerate
  task automatic test_reset_state();
    send_pixel(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
    send_pixel(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
  endtask

  // Right triangle of 256 units: vertices, centroid, outside and far pixels
  task automatic test_reference_triangle();
    load_triangle(0, 0, 256, 0, 0, 256, 256);
    send_pixel(0, 0);
    send_pixel(256, 0);
    send_pixel(0, 256);
    send_pixel(85, 85);
    send_pixel(-256, -256);
    send_pixel(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
  endtask

  // Clockwise winding gives a negative area
  task automatic test_winding();
    load_triangle(100, -50, -300, 400, 700, 200, 256);
    send_pixel(100, -50);
    send_pixel(166, 183);
    send_pixel(-1000, 3);
  endtask

  // Triangle spanning the whole coordinate range
  task automatic test_full_range();
    load_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0);
    send_pixel(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    send_pixel(COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
    send_pixel(0, -1);
  endtask

  // Triangle with unit legs in a corner, with pixels at distant corners
  task automatic test_saturation();
    load_triangle(COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MIN, COORD_MIN,
                  COORD_MIN + 1, 0);
    send_pixel(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX));
    send_pixel(COORD_W'(COORD_MAX), COORD_W'(COORD_MIN));
  endtask

  // Collinear vertices away from the origin
  task automatic test_collinear();
    load_triangle(16, 16, 32, 32, -48, -48, 0);
    send_pixel(16, 16);
    send_pixel(-7, 900);
  endtask

  // Writes past the register map must leave the vertices unchanged
  task automatic test_unmapped_index();
    load_triangle(-400, -400, 400, -400, 0, 400, 256);
    write_unmapped();
    send_pixel(0, 0);
    send_pixel(-400, -400);
  endtask

  // Hold the output long enough to fill the pipeline and stall the input
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    load_triangle(-512, -512, 1024, -256, 0, 900, 512);
    @(posedge clk);
    sink_hold_cycles = 3 * PIPE_LATENCY + 100;
    repeat (2 * PIPE_LATENCY + 20)
      send_random_pixel();
    drain_results();
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct, input int budget);
    int sent, count;
    sent           = 0;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    while (sent < budget) begin
      drain_results();
      if ($urandom_range(9) == 0)
        write_unmapped();
      load_random_triangle();
      count = $urandom_range(8, 60);
      repeat (count)
        send_random_pixel();
      sent += count;
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst              = 1'b1;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    pixel_x          = '0;
    pixel_y          = '0;
    out_stall        = 1'b0;
    src_idle_pct     = 10;
    sink_stall_pct   = 10;
    sink_hold_cycles = 0;
    foreach (vertex_reg[k])
      vertex_reg[k] = '0;
    repeat (4)
      @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_reference_triangle();
    test_winding();
    test_full_range();
    test_saturation();
    test_collinear();
    test_unmapped_index();
    test_backpressure();
    test_random_phase(26, 88, 540);
    test_random_phase(88, 26, 540);
    test_random_phase(0, 0, 540);

    drain_results();
    repeat (PIPE_LATENCY + 8)
      @(posedge clk);
    if (mismatch_count == 0 && pending_weights.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
